// ===== rtl/core/base64_stream_codec_assert.svh =====
// ----------------------------------------------------------------------------
// base64_stream_codec assertion macros
// Concurrent checks used by the codec modules; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH
`ifndef SYNTH
`define B64SC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define B64SC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define B64SC_ASSERT(lbl, clk, rst, prop, msg)
`define B64SC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/b64sc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int TOTAL_W        = 16;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;  // '='
  localparam logic [6:0] BAD_VALUE = 7'd64;

  // register index decoded from paddr[2]
  localparam logic REG_MODE = 1'b0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // one queue entry: the words caused by a single input word
  typedef struct packed {
    logic [3:0][7:0]     bytes;
    logic [1:0]          last_idx;
    logic                has_byte;
    logic                last;
    logic                status;
    logic [TOTAL_W-1:0]  total;
  } b64sc_job_t;

  typedef struct packed {
    logic       valid;
    b64sc_job_t job;
  } b64sc_head_t;

  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      return wide + 8'h41;
    end else if (idx < 6'd52) begin
      return wide + 8'h47;
    end else if (idx < 6'd62) begin
      return wide - 8'd4;
    end else if (idx == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // value of an alphabet character, BAD_VALUE when foreign
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      diff = c - 8'h41;
      return diff[6:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff = c - 8'h47;
      return diff[6:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff = c + 8'd4;
      return diff[6:0];
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end else begin
      return BAD_VALUE;
    end
  endfunction

endpackage

// ===== rtl/core/b64sc_in_if.sv =====
// ----------------------------------------------------------------------------
// b64sc_in_if
// Input word channel of the codec: one byte or character per word.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/b64sc_out_if.sv =====
// ----------------------------------------------------------------------------
// b64sc_out_if
// Result word channel of the codec: byte plus end-of-message status.
// ----------------------------------------------------------------------------
interface b64sc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        out_last;
  logic        status;
  logic [15:0] total_count;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  output status, output total_count, input ready);
  modport sink (input valid, input out_byte, input has_byte, input out_last,
                input status, input total_count, output ready);
endinterface

// ===== rtl/core/base64_stream_codec.sv =====
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder over a byte stream with an APB mode register.
// ----------------------------------------------------------------------------
// Usage: write mode (address 0, bit 0) while idle: 0 encodes, 1 decodes; the
// write also starts a fresh message. Feed words on feed (in_byte, in_last)
// and take words from result. Encode turns each 3 bytes into 4 characters,
// padding the final group with '='. Decode turns each 4-character quad into
// 3, 2 or 1 bytes. The word flagged out_last closes the message and carries
// status (1 = malformed text) and total_count (saturating byte count); when
// the message yields nothing it is a lone word with has_byte low.
// The job of an input word is written into a queue slot and then loaded
// into the result register. Throughput: the front takes one word a cycle
// while the 4-entry job queue has room; the back sends one result word a
// cycle while the receiver is ready, so the result register limits encode.
// Reset clears mode to encode and empties the queue and the result stage.
// A stalled receiver holds the result word; the queue then fills and feed
// ready drops until words drain again.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
  parameter int COUNT_BITS = b64sc_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  b64sc_in_if.sink    feed,
  b64sc_out_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  b64sc_pkg::mode_t      mode;
  logic                  cfg_write;
  logic                  fire;
  logic                  push;
  logic                  pop;
  logic                  full;
  b64sc_pkg::b64sc_job_t job;
  b64sc_pkg::b64sc_head_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == b64sc_pkg::REG_MODE);
  assign prdata    = (paddr[2] == b64sc_pkg::REG_MODE) ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= b64sc_pkg::MODE_ENCODE;
    end else if (cfg_write) begin
      mode <= b64sc_pkg::mode_t'(pwdata[0]);
    end
  end

  assign feed.ready = !full;
  assign fire       = feed.valid && !full;

  b64sc_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_write),
    .mode    (mode),
    .fire    (fire),
    .in_byte (feed.in_byte),
    .in_last (feed.in_last),
    .push    (push),
    .job     (job)
  );

  b64sc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .job  (job),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  b64sc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .oready  (result.ready),
    .ovalid  (result.valid),
    .obyte   (result.out_byte),
    .ohas    (result.has_byte),
    .olast   (result.out_last),
    .ostatus (result.status),
    .ototal  (result.total_count)
  );

endmodule

// ===== rtl/core/b64sc_front.sv =====
// ----------------------------------------------------------------------------
// b64sc_front
// Classifies each accepted word, updates group state and builds one job.
// ----------------------------------------------------------------------------
module b64sc_front #(
  parameter int COUNT_BITS = b64sc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  b64sc_pkg::mode_t      mode,
  input  logic                  fire,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  push,
  output b64sc_pkg::b64sc_job_t job
);

  logic [23:0]           group_bits;
  logic [1:0]            group_fill;
  logic [1:0]            pad_seen;
  logic                  decode_stopped;
  logic                  error_seen;
  logic [COUNT_BITS-1:0] emitted_count;

  logic [23:0]           group_bits_next;
  logic [1:0]            group_fill_next;
  logic [1:0]            pad_seen_next;
  logic                  decode_stopped_next;
  logic                  error_seen_next;
  logic [COUNT_BITS-1:0] emitted_count_next;

  logic [23:0]           enc_shift;
  logic [23:0]           enc_bits;
  logic [2:0]            fill_inc;
  logic [23:0]           dec_shift;
  logic [6:0]            value;
  logic                  is_pad;
  logic [2:0]            pad_inc;
  logic [1:0]            pad_new;
  logic [2:0]            n_words;
  logic [3:0][7:0]       words;
  logic [COUNT_BITS:0]   count_sum;
  logic [31:0]           count_wide;

  always_comb begin
    group_bits_next     = group_bits;
    group_fill_next     = group_fill;
    pad_seen_next       = pad_seen;
    decode_stopped_next = decode_stopped;
    error_seen_next     = error_seen;
    n_words             = 3'd0;
    words               = '0;
    fill_inc            = {1'b0, group_fill} + 3'd1;
    enc_shift           = {group_bits[15:0], in_byte};
    enc_bits            = enc_shift;
    value               = b64sc_pkg::dec_value(in_byte);
    is_pad              = (in_byte == b64sc_pkg::PAD_CHAR);
    pad_inc             = {1'b0, pad_seen} + 3'd1;
    pad_new             = pad_seen;
    dec_shift           = {group_bits[17:0], 6'd0};

    if (mode == b64sc_pkg::MODE_ENCODE) begin
      if (fill_inc == 3'd3 || in_last) begin
        case (fill_inc)
          3'd1:    enc_bits = {enc_shift[7:0], 16'd0};
          3'd2:    enc_bits = {enc_shift[15:0], 8'd0};
          default: enc_bits = enc_shift;
        endcase
        for (int k = 0; k < 4; k++) begin
          if (3'(k) > fill_inc) begin
            words[k] = b64sc_pkg::PAD_CHAR;
          end else begin
            words[k] = b64sc_pkg::enc_char(enc_bits[23 - 6*k -: 6]);
          end
        end
        n_words         = 3'd4;
        group_bits_next = '0;
        group_fill_next = '0;
      end else begin
        group_bits_next = enc_shift;
        group_fill_next = fill_inc[1:0];
      end
    end else if (!decode_stopped && !error_seen) begin
      if (group_fill == 2'd0 && value == b64sc_pkg::BAD_VALUE && !is_pad) begin
        decode_stopped_next = 1'b1;
      end else if (is_pad && pad_inc == 3'd3) begin
        error_seen_next = 1'b1;
      end else if (!is_pad && (value == b64sc_pkg::BAD_VALUE || pad_seen != 2'd0)) begin
        error_seen_next = 1'b1;
      end else begin
        // good character or an allowed '=' (value zero)
        if (is_pad) begin
          pad_new = pad_inc[1:0];
        end else begin
          dec_shift[5:0] = value[5:0];
        end
        if (fill_inc == 3'd4) begin
          words[0] = dec_shift[23:16];
          words[1] = dec_shift[15:8];
          words[2] = dec_shift[7:0];
          case (pad_new)
            2'd0:    n_words = 3'd3;
            2'd1:    n_words = 3'd2;
            default: n_words = 3'd1;
          endcase
          group_bits_next = '0;
          group_fill_next = '0;
          pad_seen_next   = '0;
        end else begin
          group_bits_next = dec_shift;
          group_fill_next = fill_inc[1:0];
          pad_seen_next   = pad_new;
        end
      end
    end

    // message ending inside a quad
    if (in_last && mode == b64sc_pkg::MODE_DECODE && !decode_stopped_next &&
        !error_seen_next && group_fill_next != 2'd0) begin
      error_seen_next = 1'b1;
    end

    count_sum = {1'b0, emitted_count} + (COUNT_BITS+1)'(n_words);
    if (count_sum[COUNT_BITS]) begin
      emitted_count_next = '1;
    end else begin
      emitted_count_next = count_sum[COUNT_BITS-1:0];
    end
    count_wide = 32'(emitted_count_next);

    push         = fire && (n_words != 3'd0 || in_last);
    job.bytes    = words;
    job.last_idx = (n_words == 3'd0) ? 2'd0 : 2'(n_words - 3'd1);
    job.has_byte = (n_words != 3'd0);
    job.last     = in_last;
    job.status   = error_seen_next;
    job.total    = count_wide[b64sc_pkg::TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || clear || (fire && in_last)) begin
      group_bits     <= '0;
      group_fill     <= '0;
      pad_seen       <= '0;
      decode_stopped <= 1'b0;
      error_seen     <= 1'b0;
      emitted_count  <= '0;
    end else if (fire) begin
      group_bits     <= group_bits_next;
      group_fill     <= group_fill_next;
      pad_seen       <= pad_seen_next;
      decode_stopped <= decode_stopped_next;
      error_seen     <= error_seen_next;
      emitted_count  <= emitted_count_next;
    end
  end

endmodule

// ===== rtl/core/b64sc_queue.sv =====
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module b64sc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  b64sc_pkg::b64sc_job_t  job,
  input  logic                   pop,
  output logic                   full,
  output b64sc_pkg::b64sc_head_t head
);

  localparam int DEPTH = b64sc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64sc_pkg::b64sc_job_t slots [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `B64SC_ASSERT(a_no_overflow, clk, rst, push |-> !full, "job pushed into a full queue")
  `B64SC_ASSERT(a_no_underflow, clk, rst, pop |-> head.valid, "job popped from an empty queue")
  `B64SC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/core/b64sc_back.sv =====
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the head job into the registered result stage, one word a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module b64sc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  b64sc_pkg::b64sc_head_t head,
  output logic                   pop,
  input  logic                   oready,
  output logic                   ovalid,
  output logic [7:0]             obyte,
  output logic                   ohas,
  output logic                   olast,
  output logic                   ostatus,
  output logic [15:0]            ototal
);

  logic [1:0] idx;
  logic       load;
  logic       final_word;

  assign load       = head.valid && (!ovalid || oready);
  assign final_word = (idx == head.job.last_idx);
  assign pop        = load && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= final_word ? 2'd0 : idx + 2'd1;
      end else if (oready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // payload: status and count only ride on the final word of a message
  always_ff @(posedge clk) begin
    if (load) begin
      obyte   <= head.job.bytes[idx];
      ohas    <= head.job.has_byte;
      olast   <= head.job.last && final_word;
      ostatus <= head.job.status && head.job.last && final_word;
      ototal  <= (head.job.last && final_word) ? head.job.total : 16'd0;
    end
  end

  `B64SC_ASSERT(a_marker_is_final, clk, rst, ovalid && !ohas |-> olast, "empty word is not final")
  `B64SC_ASSERT(a_status_on_final, clk, rst, ovalid && !olast |-> !ostatus && ototal == 16'd0, "status outside final word")
  `B64SC_ASSERT_NEXT(a_hold_word, clk, rst, ovalid && !oready, ovalid, "result word dropped while stalled")

endmodule

// ===== tb/base64_stream_codec_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_codec_checker
// Watches the feed, result and APB ports of the codec, keeps its own model of
// the encoder and decoder state, and compares every result word field by field
// against the oldest predicted word. Mismatches are counted for the test top.
// ----------------------------------------------------------------------------
module base64_stream_codec_checker (
  input  logic        clk,
  input  logic        rst,
  b64sc_in_if         feed,
  b64sc_out_if        result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  localparam string B64_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  data;
    logic        has_byte;
    logic        last;
    logic        status;
    logic [15:0] total;
  } codec_word_t;

  codec_word_t expected_words[$];

  b64sc_pkg::mode_t codec_mode;
  logic [23:0]      grp_bits;
  int               grp_fill;
  int               pad_count;
  logic             dec_stopped;
  logic             dec_error;
  logic [15:0]      emitted;
  int               words_made;

  function automatic logic [6:0] alphabet_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (B64_CHARS[i] == c) begin
        return 7'(i);
      end
    end
    return b64sc_pkg::BAD_VALUE;
  endfunction

  task automatic clear_message();
    grp_bits    = '0;
    grp_fill    = 0;
    pad_count   = 0;
    dec_stopped = 1'b0;
    dec_error   = 1'b0;
    emitted     = '0;
  endtask

  task automatic push_word(input logic [7:0] data);
    codec_word_t w;
    w          = '0;
    w.data     = data;
    w.has_byte = 1'b1;
    expected_words.push_back(w);
    words_made++;
    if (emitted != COUNT_MAX) begin
      emitted++;
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] bits;
    logic [5:0]  idx;
    grp_bits = {grp_bits[15:0], b};
    grp_fill++;
    if (grp_fill == 3 || last) begin
      // zero-fill a short group, then pad the unused characters
      bits = grp_bits << (8 * (3 - grp_fill));
      for (int k = 0; k < 4; k++) begin
        idx = bits[23 - 6 * k -: 6];
        push_word(k > grp_fill ? b64sc_pkg::PAD_CHAR : 8'(B64_CHARS[idx]));
      end
      grp_bits = '0;
      grp_fill = 0;
    end
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [6:0] v;
    if (dec_stopped || dec_error) begin
      return;
    end
    v = alphabet_index(c);
    if (grp_fill == 0 && v == b64sc_pkg::BAD_VALUE && c != b64sc_pkg::PAD_CHAR) begin
      dec_stopped = 1'b1;
      return;
    end
    if (c == b64sc_pkg::PAD_CHAR) begin
      pad_count++;
      v = '0;
      if (pad_count > 2) begin
        dec_error = 1'b1;
        return;
      end
    end else if (v == b64sc_pkg::BAD_VALUE || pad_count != 0) begin
      dec_error = 1'b1;
      return;
    end
    grp_bits = {grp_bits[17:0], v[5:0]};
    grp_fill++;
    if (grp_fill == 4) begin
      push_word(grp_bits[23:16]);
      if (pad_count < 2) begin
        push_word(grp_bits[15:8]);
      end
      if (pad_count < 1) begin
        push_word(grp_bits[7:0]);
      end
      grp_bits  = '0;
      grp_fill  = 0;
      pad_count = 0;
    end
  endtask

  task automatic codec_step(input logic [7:0] b, input logic last);
    codec_word_t w;
    words_made = 0;
    if (codec_mode == b64sc_pkg::MODE_ENCODE) begin
      encode_byte(b, last);
    end else begin
      decode_char(b);
    end
    if (!last) begin
      return;
    end
    // message ended inside a quad
    if (codec_mode == b64sc_pkg::MODE_DECODE && !dec_stopped && !dec_error &&
        grp_fill != 0) begin
      dec_error = 1'b1;
    end
    if (words_made == 0) begin
      expected_words.push_back('0);
    end
    w        = expected_words[$];
    w.last   = 1'b1;
    w.status = dec_error;
    w.total  = emitted;
    expected_words[$] = w;
    clear_message();
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    codec_word_t w;
    if (rst) begin
      codec_mode = b64sc_pkg::MODE_ENCODE;
      clear_message();
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == b64sc_pkg::REG_MODE) begin
        codec_mode = b64sc_pkg::mode_t'(pwdata[0]);
        clear_message();
      end
      if (feed.valid && feed.ready) begin
        codec_step(feed.in_byte, feed.in_last);
      end
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got byte %h has %b last %b",
                   $time, result.out_byte, result.has_byte, result.out_last);
        end else begin
          w = expected_words.pop_front();
          check_field("out_byte", 16'(w.data), 16'(result.out_byte));
          check_field("has_byte", 16'(w.has_byte), 16'(result.has_byte));
          check_field("out_last", 16'(w.last), 16'(result.out_last));
          check_field("status", 16'(w.status), 16'(result.status));
          check_field("total_count", w.total, result.total_count);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/base64_stream_codec_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_codec_test
// Drives encode and decode messages into the codec: a directed set of edge
// cases, then random well-formed and broken messages under several idle and
// stall patterns, including a long receiver hold-off. Checking is done by the
// checker instance; this top gives the verdict.
// ----------------------------------------------------------------------------
module base64_stream_codec_test;

  localparam int         STALL_LIMIT = 5000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 26;
  localparam logic [2:0] MODE_ADDR   = {b64sc_pkg::REG_MODE, 2'b00};
  localparam string      B64_CHARS   =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef logic [7:0] char_q_t[$];

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;

  int feed_gap_pct;
  int result_stall_pct;
  int hold_reqs;
  int holds_done;
  int hold_left;
  int quiet_cycles;

  b64sc_in_if  feed_if ();
  b64sc_out_if result_if ();

  base64_stream_codec DUT (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  base64_stream_codec_checker codec_check (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed_if),
    .result     (result_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      holds_done = hold_reqs;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left--;
    end else if (holds_done != hold_reqs) begin
      result_if.ready <= 1'b0;
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= result_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("base64_stream_codec_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < feed_gap_pct) begin
      feed_if.valid <= 1'b0;
      @(posedge clk);
    end
    feed_if.valid   <= 1'b1;
    feed_if.in_byte <= b;
    feed_if.in_last <= last;
    @(posedge clk);
    while (!feed_if.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_msg(input char_q_t m);
    foreach (m[i]) begin
      send_word(m[i], i == m.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    char_q_t m;
    foreach (s[i]) begin
      m.push_back(s[i]);
    end
    send_msg(m);
  endtask

  // hold off until every predicted word has drained, then let the pipe empty
  task automatic settle();
    feed_if.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input b64sc_pkg::mode_t m);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic char_q_t random_bytes(input int len);
    char_q_t m;
    for (int i = 0; i < len; i++) begin
      m.push_back(8'($urandom_range(255)));
    end
    return m;
  endfunction

  function automatic logic [7:0] random_alpha();
    return 8'(B64_CHARS[$urandom_range(63)]);
  endfunction

  // well-formed text; padding may also close a quad in mid-stream
  function automatic char_q_t random_quads();
    char_q_t m;
    int      nq;
    int      npad;
    nq = $urandom_range(1, 3);
    for (int q = 0; q < nq; q++) begin
      npad = 0;
      if (q == nq - 1 || $urandom_range(3) == 0) begin
        npad = $urandom_range(0, 2);
      end
      for (int k = 0; k < 4; k++) begin
        m.push_back(k >= 4 - npad ? b64sc_pkg::PAD_CHAR : random_alpha());
      end
    end
    return m;
  endfunction

  function automatic char_q_t random_noise();
    char_q_t m;
    int      len;
    int      pick;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        m.push_back(random_alpha());
      end else if (pick < 7) begin
        m.push_back(b64sc_pkg::PAD_CHAR);
      end else begin
        m.push_back(8'($urandom_range(255)));
      end
    end
    return m;
  endfunction

  initial begin
    char_q_t m;
    int      items;
    logic    pressed;
    rst               = 1'b1;
    feed_if.valid     = 1'b0;
    feed_if.in_byte   = '0;
    feed_if.in_last   = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    feed_gap_pct      = 0;
    result_stall_pct  = 0;
    hold_reqs         = 0;
    pressed           = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full group, two-pad and one-pad tails
    write_mode(b64sc_pkg::MODE_ENCODE);
    send_msg('{8'h00, 8'hFF, 8'h80, 8'h5A});
    send_msg('{8'h01, 8'hFE});
    settle();
    // directed: padding mid-stream, foreign start, foreign inside,
    // third pad, data after pad, truncated quad
    write_mode(b64sc_pkg::MODE_DECODE);
    send_text("TW==/+9z");
    send_text("*");
    send_text("A*");
    send_text("A===");
    send_text("AB=C");
    send_text("AB");
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          feed_gap_pct     = 0;
          result_stall_pct = 0;
        end
        1: begin
          feed_gap_pct     = 82;
          result_stall_pct = 0;
        end
        2: begin
          feed_gap_pct     = 0;
          result_stall_pct = 82;
        end
        default: begin
          feed_gap_pct     = 17;
          result_stall_pct = 17;
        end
      endcase

      write_mode(b64sc_pkg::MODE_ENCODE);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (ph == 0 && !pressed && items > 8) begin
          // keep feeding while the receiver holds off so the queue backs up
          hold_reqs++;
          m = random_bytes(30);
          pressed = 1'b1;
        end else begin
          m = random_bytes($urandom_range(1, 8));
        end
        send_msg(m);
        items += m.size();
      end
      settle();

      write_mode(b64sc_pkg::MODE_DECODE);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          send_msg(random_noise());
        end else begin
          m = random_quads();
          send_msg(m);
          items += m.size();
        end
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("base64_stream_codec_test OK");
    end else begin
      $display("base64_stream_codec_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/b64sc_pkg.sv
rtl/core/b64sc_in_if.sv
rtl/core/b64sc_out_if.sv
rtl/core/b64sc_front.sv
rtl/core/b64sc_queue.sv
rtl/core/b64sc_back.sv
rtl/core/base64_stream_codec.sv
tb/base64_stream_codec_checker.sv
tb/base64_stream_codec_test.sv
